FILE: rtl/ugw_pkg.sv
// Shared constants, codes and types of the uniform grid ray voxel walker.
`timescale 1ns / 1ps
`default_nettype none
package ugw_pkg;

    // Default sizing
    localparam int DEF_MAX_SUBDIVISIONS = 64;
    localparam int DEF_FRACTION_BITS    = 16;

    // Divider geometry: 64-bit dividend, 32-bit divisor, 33 quotient bits
    localparam int DVD_W = 64;
    localparam int DVS_W = 32;
    localparam int QUO_W = 33;

    // Output field widths
    localparam int IDX_W  = 18;
    localparam int VOX_W  = 6;
    localparam int DIST_W = 31;

    // Saturation limits of a ray parameter
    localparam logic signed [31:0] T_HI = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] T_LO = 32'sh8000_0000;

    // Verdict codes
    localparam logic [1:0] VERDICT_TEST = 2'd0;
    localparam logic [1:0] VERDICT_HIT  = 2'd1;
    localparam logic [1:0] VERDICT_MISS = 2'd2;

    // Input item kinds
    localparam logic KIND_RAY    = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_MIN_X  = 3'd0;
    localparam logic [2:0] REG_MIN_Y  = 3'd1;
    localparam logic [2:0] REG_MIN_Z  = 3'd2;
    localparam logic [2:0] REG_CELL_X = 3'd3;
    localparam logic [2:0] REG_CELL_Y = 3'd4;
    localparam logic [2:0] REG_CELL_Z = 3'd5;
    localparam logic [2:0] REG_SUBDIV = 3'd6;

    // Divider status toward the sequencer
    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

endpackage
`default_nettype wire

FILE: rtl/uniform_grid_ray_voxel_walker.sv
// Top level: 3D DDA voxel walker over a uniform grid, sequencer around a shared divider.
//
// Usage: write the grid bounds, cell sizes and subdivisions on the cfg port while idle.
// Send a ray transaction (s_tuser = 0) carrying origin and direction; the block clips
// it against the grid and answers either a miss or the first voxel to test. Then send
// a test-result transaction (s_tuser = 1) per voxel with the external tester's hit
// flag and distance; each answer is a hit, the next voxel to test, or a miss.
// One item is in work at a time: s_tready is high only when the sequencer is idle.
// Ray setup runs up to twelve divisions on the single shared divider (three clip
// divides, three cell index divides, six boundary divides), plus multiply and
// bookkeeping steps; a ray that misses early ends before most of them. A test result
// answers a hit or a miss straight after the compare, and a step after the compare,
// two index multiply steps and the output load.
// The result goes to an output register; the next item is accepted while it waits.
// If the receiver stalls, a finished item holds in the sequencer until the output
// register frees. Reset clears the walk state and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module uniform_grid_ray_voxel_walker
    import ugw_pkg::*;
#(
    parameter int MAX_SUBDIVISIONS = DEF_MAX_SUBDIVISIONS,
    parameter int FRACTION_BITS    = DEF_FRACTION_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration write port
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wr_data,
    // input channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
    // hit_found, hit_distance
    input  wire logic [223:0] s_tdata,
    // kind
    input  wire logic [0:0]   s_tuser,
    // result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // verdict, voxel_index, voxel_x, voxel_y, voxel_z, reported_distance, zero pad
    output logic [71:0]       m_tdata
);

    localparam int NB  = $clog2(MAX_SUBDIVISIONS + 1);
    localparam int CW  = $clog2(MAX_SUBDIVISIONS);
    localparam int NW  = 34 + NB;
    localparam int LKW = CW + NB + 1;
    localparam int L2W = LKW + NB + 1;
    localparam int BIG_SH = 62 - FRACTION_BITS;
    localparam logic signed [31:0] GRID_EPS = 32'((2 ** FRACTION_BITS + 500) / 1000);
    localparam logic signed [31:0] BEST_INIT = -(32'sd1 <<< FRACTION_BITS);

    typedef enum logic [4:0] {
        S_IDLE, S_TEST, S_MXM, S_MXA, S_CLIP, S_CDIV, S_CEND, S_CMUL, S_CMULW,
        S_IDX, S_IDXW, S_BMUL, S_BMULW, S_BDIV1, S_BDIV2, S_LINK1, S_LINK2, S_OUT
    } state_t;

    // Configuration registers
    logic signed [31:0] mn_reg [3];
    logic [30:0]        cs_reg [3];
    logic [6:0]         subdiv_reg;

    // Sequencer and walk state
    state_t             state_reg;
    logic [1:0]         ax_reg;
    logic               walking_reg;
    logic [CW-1:0]      coord_reg [3];
    logic [IDX_W-1:0]   lin_reg;
    logic signed [31:0] nb_reg [3];
    logic signed [31:0] bs_reg [3];
    logic               stepneg_reg [3];

    // Per-ray working set
    logic signed [31:0] o_reg [3];
    logic signed [31:0] d_reg [3];
    logic signed [NW-1:0] mx_reg [3];
    logic signed [NW-1:0] st_reg [3];
    logic signed [NW-1:0] tgt_reg;
    logic signed [31:0] best_reg;
    logic [1:0]         cand_reg;
    logic               cand_vld_reg;
    logic               hit_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [LKW-1:0]     tmp_reg;
    logic               neg_reg;
    logic               big_reg;
    logic signed [65:0] prod_reg;

    // Result staging and output register
    logic [1:0]         res_verdict_reg;
    logic [DIST_W-1:0]  res_dist_reg;
    logic               m_tvalid_reg;
    logic [71:0]        m_tdata_reg;

    // Effective register values
    logic [NB-1:0] n_eff;
    logic [30:0]   cs_eff [3];

    always_comb begin
        if (subdiv_reg == 7'd0) begin
            n_eff = NB'(1);
        end else if (int'(subdiv_reg) > MAX_SUBDIVISIONS) begin
            n_eff = NB'(MAX_SUBDIVISIONS);
        end else begin
            n_eff = NB'(subdiv_reg);
        end
        for (int a = 0; a < 3; a++) begin
            cs_eff[a] = (cs_reg[a] == 31'd0) ? 31'd1 : cs_reg[a];
        end
    end

    // Current axis operands
    logic signed [31:0]   o_cur, d_cur, mn_cur;
    logic signed [NW-1:0] o_ext, mn_ext, mx_cur;
    logic [30:0]          cs_cur;
    logic                 o_lt_mn, o_gt_mx, d_pos;

    assign o_cur   = o_reg[ax_reg];
    assign d_cur   = d_reg[ax_reg];
    assign mn_cur  = mn_reg[ax_reg];
    assign cs_cur  = cs_eff[ax_reg];
    assign mx_cur  = mx_reg[ax_reg];
    assign o_ext   = NW'(o_cur);
    assign mn_ext  = NW'(mn_cur);
    assign o_lt_mn = o_cur < mn_cur;
    assign o_gt_mx = o_ext > mx_cur;
    assign d_pos   = d_cur > 32'sd0;

    // Shared multiplier, registered product
    logic signed [32:0] mul_a, mul_b;
    logic [NB-1:0]      idx_inc;

    assign idx_inc = NB'(coord_reg[ax_reg]) + NB'(d_pos);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MXM: begin
                mul_a = 33'(n_eff);
                mul_b = 33'(cs_cur);
            end
            S_CMUL: begin
                mul_a = 33'(best_reg);
                mul_b = 33'(d_cur);
            end
            S_BMUL: begin
                mul_a = 33'(idx_inc);
                mul_b = 33'(cs_cur);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Divider request: signed numerator and denominator per state
    div_stat_t            div_stat;
    logic [QUO_W-1:0]     div_quo;
    logic                 div_go;
    logic                 dv_tdiv;
    logic signed [NW-1:0] dv_num;
    logic signed [32:0]   dv_den;
    logic [NW-1:0]        num_abs;
    logic [DVS_W-1:0]     den_abs;
    logic [DVD_W-1:0]     dv_dvd;

    always_comb begin
        div_go  = 1'b0;
        dv_tdiv = 1'b1;
        dv_num  = '0;
        dv_den  = '0;
        case (state_reg)
            S_CLIP: begin
                if (o_lt_mn && !(d_cur < GRID_EPS)) begin
                    div_go = 1'b1;
                    dv_num = mn_ext - o_ext;
                    dv_den = 33'(d_cur);
                end else if (!o_lt_mn && o_gt_mx && !(d_cur > -GRID_EPS)) begin
                    div_go = 1'b1;
                    dv_num = mx_cur - o_ext;
                    dv_den = 33'(d_cur);
                end
            end
            S_IDX: begin
                div_go  = 1'b1;
                dv_tdiv = 1'b0;
                dv_num  = st_reg[ax_reg] - mn_ext;
                dv_den  = 33'(cs_cur);
            end
            S_BMULW: begin
                if (d_cur != 32'sd0) begin
                    div_go = 1'b1;
                    dv_num = mn_ext + NW'(prod_reg) - o_ext;
                    dv_den = 33'(d_cur);
                end
            end
            S_BDIV1: begin
                if (div_stat.done) begin
                    div_go = 1'b1;
                    dv_num = NW'(cs_cur);
                    dv_den = d_pos ? 33'(d_cur) : -33'(d_cur);
                end
            end
            default: begin
                div_go = 1'b0;
            end
        endcase
        num_abs = (dv_num < 0) ? NW'(-dv_num) : NW'(dv_num);
        den_abs = (dv_den < 0) ? DVS_W'(-dv_den) : DVS_W'(dv_den);
        dv_dvd  = dv_tdiv ? (DVD_W'(num_abs) << FRACTION_BITS) : DVD_W'(num_abs);
    end

    ugw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_go),
        .dividend (dv_dvd),
        .divisor  (den_abs),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // Signed, saturated quotient
    logic               huge;
    logic signed [31:0] tq;

    assign huge = big_reg || div_stat.ovf;

    always_comb begin
        if (neg_reg) begin
            tq = (huge || div_quo > QUO_W'(33'h0_8000_0000)) ? T_LO : -div_quo[31:0];
        end else begin
            tq = (huge || div_quo > QUO_W'(33'h0_7FFF_FFFF)) ? T_HI : div_quo[31:0];
        end
    end

    // Clamped cell index from an index division
    logic [CW-1:0] idx_new;

    always_comb begin
        if (neg_reg) begin
            idx_new = '0;
        end else if (div_quo > QUO_W'(n_eff - 1'b1)) begin
            idx_new = CW'(n_eff - 1'b1);
        end else begin
            idx_new = CW'(div_quo);
        end
    end

    // Clip point along a non-entry axis
    logic signed [66:0] st_calc;
    logic               st_out;

    assign st_calc = 67'(o_cur) + (67'(prod_reg) >>> FRACTION_BITS);
    assign st_out  = (st_calc < 67'(mn_ext)) || (st_calc > 67'(mx_cur));

    // Test result: nearest boundary, hit check and step
    logic [1:0]         sel;
    logic signed [31:0] tm_sel;
    logic               is_hit;
    logic [CW:0]        nc;
    logic               leave;
    logic signed [32:0] nb_sum;
    logic signed [31:0] nb_sat;

    always_comb begin
        if (nb_reg[0] < nb_reg[1]) begin
            sel = (nb_reg[0] < nb_reg[2]) ? 2'd0 : 2'd2;
        end else begin
            sel = (nb_reg[1] < nb_reg[2]) ? 2'd1 : 2'd2;
        end
        tm_sel = nb_reg[sel];
        is_hit = hit_reg && (33'(signed'({1'b0, dist_reg})) <= 33'(tm_sel));
        nc     = stepneg_reg[sel] ? ({1'b0, coord_reg[sel]} - 1'b1)
                                  : ({1'b0, coord_reg[sel]} + 1'b1);
        leave  = nc[CW] || (nc[CW-1:0] >= n_eff);
        nb_sum = 33'(nb_reg[sel]) + 33'(bs_reg[sel]);
        if (nb_sum > 33'(T_HI)) begin
            nb_sat = T_HI;
        end else if (nb_sum < 33'(T_LO)) begin
            nb_sat = T_LO;
        end else begin
            nb_sat = 32'(nb_sum);
        end
    end

    // Linear index pieces
    logic [LKW-1:0] link1;
    logic [L2W-1:0] link2;

    assign link1 = LKW'(coord_reg[2]) * LKW'(n_eff) + LKW'(coord_reg[1]);
    assign link2 = L2W'(tmp_reg) * L2W'(n_eff) + L2W'(coord_reg[0]);

    logic out_free;
    logic last_ax;

    assign out_free = !m_tvalid_reg || m_tready;
    assign last_ax  = ax_reg == 2'd2;

    // Result word: fields shown by verdict, zero elsewhere
    logic [71:0] out_word;

    always_comb begin
        out_word       = '0;
        out_word[1:0]  = res_verdict_reg;
        if (res_verdict_reg != VERDICT_MISS) begin
            out_word[19:2]  = lin_reg;
            out_word[25:20] = VOX_W'(coord_reg[0]);
            out_word[31:26] = VOX_W'(coord_reg[1]);
            out_word[37:32] = VOX_W'(coord_reg[2]);
        end
        if (res_verdict_reg == VERDICT_HIT) begin
            out_word[68:38] = res_dist_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                mn_reg[a] <= '0;
                cs_reg[a] <= 31'd65536;
            end
            subdiv_reg <= 7'd16;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MIN_X:  mn_reg[0]  <= cfg_wr_data;
                REG_MIN_Y:  mn_reg[1]  <= cfg_wr_data;
                REG_MIN_Z:  mn_reg[2]  <= cfg_wr_data;
                REG_CELL_X: cs_reg[0]  <= cfg_wr_data[30:0];
                REG_CELL_Y: cs_reg[1]  <= cfg_wr_data[30:0];
                REG_CELL_Z: cs_reg[2]  <= cfg_wr_data[30:0];
                REG_SUBDIV: subdiv_reg <= cfg_wr_data[6:0];
                default:    subdiv_reg <= subdiv_reg;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ax_reg       <= '0;
            walking_reg  <= 1'b0;
            lin_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            cand_vld_reg <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                coord_reg[a]   <= '0;
                nb_reg[a]      <= '0;
                bs_reg[a]      <= '0;
                stepneg_reg[a] <= 1'b0;
            end
        end else begin
            // raise the output when a result is loaded, drop it once taken
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (div_go) begin
                neg_reg <= (dv_num < 0) != (dv_den < 0);
                big_reg <= dv_tdiv && ((num_abs >> BIG_SH) != '0);
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        o_reg[0] <= s_tdata[31:0];
                        o_reg[1] <= s_tdata[63:32];
                        o_reg[2] <= s_tdata[95:64];
                        d_reg[0] <= s_tdata[127:96];
                        d_reg[1] <= s_tdata[159:128];
                        d_reg[2] <= s_tdata[191:160];
                        hit_reg  <= s_tdata[192];
                        dist_reg <= s_tdata[223:193];
                        st_reg[0] <= NW'($signed(s_tdata[31:0]));
                        st_reg[1] <= NW'($signed(s_tdata[63:32]));
                        st_reg[2] <= NW'($signed(s_tdata[95:64]));
                        ax_reg       <= '0;
                        best_reg     <= BEST_INIT;
                        cand_vld_reg <= 1'b0;
                        if (s_tuser[0] == KIND_RESULT) begin
                            state_reg <= S_TEST;
                        end else begin
                            walking_reg <= 1'b0;
                            state_reg   <= S_MXM;
                        end
                    end
                end
                S_TEST: begin
                    if (!walking_reg) begin
                        res_verdict_reg <= VERDICT_MISS;
                        state_reg       <= S_OUT;
                    end else if (is_hit) begin
                        walking_reg     <= 1'b0;
                        res_verdict_reg <= VERDICT_HIT;
                        res_dist_reg    <= dist_reg;
                        state_reg       <= S_OUT;
                    end else if (leave) begin
                        walking_reg     <= 1'b0;
                        res_verdict_reg <= VERDICT_MISS;
                        state_reg       <= S_OUT;
                    end else begin
                        coord_reg[sel] <= nc[CW-1:0];
                        nb_reg[sel]    <= nb_sat;
                        state_reg      <= S_LINK1;
                    end
                end
                S_MXM: begin
                    state_reg <= S_MXA;
                end
                S_MXA: begin
                    mx_reg[ax_reg] <= mn_ext + NW'(prod_reg);
                    if (last_ax) begin
                        ax_reg    <= '0;
                        state_reg <= S_CLIP;
                    end else begin
                        ax_reg    <= ax_reg + 1'b1;
                        state_reg <= S_MXM;
                    end
                end
                S_CLIP: begin
                    if (div_go) begin
                        tgt_reg   <= o_lt_mn ? mn_ext : mx_cur;
                        state_reg <= S_CDIV;
                    end else if (o_lt_mn || o_gt_mx) begin
                        res_verdict_reg <= VERDICT_MISS;
                        state_reg       <= S_OUT;
                    end else if (last_ax) begin
                        state_reg <= S_CEND;
                    end else begin
                        ax_reg <= ax_reg + 1'b1;
                    end
                end
                S_CDIV: begin
                    if (div_stat.done) begin
                        if (tq > best_reg) begin
                            best_reg       <= tq;
                            cand_reg       <= ax_reg;
                            cand_vld_reg   <= 1'b1;
                            st_reg[ax_reg] <= tgt_reg;
                        end
                        if (last_ax) begin
                            state_reg <= S_CEND;
                        end else begin
                            ax_reg    <= ax_reg + 1'b1;
                            state_reg <= S_CLIP;
                        end
                    end
                end
                S_CEND: begin
                    ax_reg <= '0;
                    if (cand_vld_reg && best_reg < 0) begin
                        res_verdict_reg <= VERDICT_MISS;
                        state_reg       <= S_OUT;
                    end else if (cand_vld_reg) begin
                        state_reg <= S_CMUL;
                    end else begin
                        state_reg <= S_IDX;
                    end
                end
                S_CMUL: begin
                    if (ax_reg != cand_reg) begin
                        state_reg <= S_CMULW;
                    end else if (last_ax) begin
                        ax_reg    <= '0;
                        state_reg <= S_IDX;
                    end else begin
                        ax_reg <= ax_reg + 1'b1;
                    end
                end
                S_CMULW: begin
                    if (st_out) begin
                        res_verdict_reg <= VERDICT_MISS;
                        state_reg       <= S_OUT;
                    end else begin
                        st_reg[ax_reg] <= NW'(st_calc);
                        if (last_ax) begin
                            ax_reg    <= '0;
                            state_reg <= S_IDX;
                        end else begin
                            ax_reg    <= ax_reg + 1'b1;
                            state_reg <= S_CMUL;
                        end
                    end
                end
                S_IDX: begin
                    state_reg <= S_IDXW;
                end
                S_IDXW: begin
                    if (div_stat.done) begin
                        coord_reg[ax_reg]   <= idx_new;
                        stepneg_reg[ax_reg] <= !d_pos;
                        state_reg           <= S_BMUL;
                    end
                end
                S_BMUL: begin
                    state_reg <= S_BMULW;
                end
                S_BMULW: begin
                    if (div_go) begin
                        state_reg <= S_BDIV1;
                    end else begin
                        nb_reg[ax_reg] <= T_HI;
                        bs_reg[ax_reg] <= T_HI;
                        if (last_ax) begin
                            state_reg <= S_LINK1;
                        end else begin
                            ax_reg    <= ax_reg + 1'b1;
                            state_reg <= S_IDX;
                        end
                    end
                end
                S_BDIV1: begin
                    if (div_stat.done) begin
                        nb_reg[ax_reg] <= tq;
                        state_reg      <= S_BDIV2;
                    end
                end
                S_BDIV2: begin
                    if (div_stat.done) begin
                        bs_reg[ax_reg] <= tq;
                        if (last_ax) begin
                            state_reg <= S_LINK1;
                        end else begin
                            ax_reg    <= ax_reg + 1'b1;
                            state_reg <= S_IDX;
                        end
                    end
                end
                S_LINK1: begin
                    tmp_reg   <= link1;
                    state_reg <= S_LINK2;
                end
                S_LINK2: begin
                    lin_reg         <= IDX_W'(link2);
                    walking_reg     <= 1'b1;
                    res_verdict_reg <= VERDICT_TEST;
                    state_reg       <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tdata_reg <= out_word;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

FILE: rtl/ugw_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, with overflow flag.
`timescale 1ns / 1ps
`default_nettype none
module ugw_div
    import ugw_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic      [QUO_W-1:0] quotient,
    output div_stat_t             stat
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [QUO_W-1:0] low_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             ovf_reg;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           take;

    // Shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, low_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign take  = trial >= {1'b0, dvs_reg};

    // Control: count the quotient bits, pulse done at the end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(QUO_W);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DVS_W'(dividend[DVD_W-1:QUO_W]);
            low_reg <= dividend[QUO_W-1:0];
            dvs_reg <= divisor;
            ovf_reg <= DVS_W'(dividend[DVD_W-1:QUO_W]) >= divisor;
        end else if (run_reg) begin
            rem_reg <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], take};
        end
    end

    assign quotient  = quo_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule
`default_nettype wire

FILE: bench/tb_uniform_grid_ray_voxel_walker.sv
// Self-checking testbench for the uniform grid ray voxel walker.
`timescale 1ns / 1ps
`default_nettype none
module tb_uniform_grid_ray_voxel_walker;
    import ugw_pkg::*;

    localparam longint EPS_Q = (65536 + 500) / 1000;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef struct {
        logic              kind;
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        logic              hit_found;
        logic [30:0]       hit_dist;
    } ray_item_t;

    typedef struct {
        logic [1:0]  verdict;
        logic [17:0] index;
        logic [5:0]  vox [3];
        logic [30:0] distance;
    } walk_answer_t;

    typedef struct {
        ray_item_t    item;
        bit           typed;
        walk_answer_t answer;
    } dir_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [223:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;

    // shadow registers and walk state of the predictor
    logic [31:0]  shadow_reg [7];
    int           cur_vox [3];
    logic [17:0]  cur_index;
    longint       t_next [3];
    longint       t_delta [3];
    bit           go_back [3];
    bit           is_walking;

    walk_answer_t answer_q [$];
    int           mismatches = 0;
    int           rays_sent = 0, results_sent = 0, answers_seen = 0, hits_seen = 0;
    bit           no_idle = 1'b0;

    uniform_grid_ray_voxel_walker dut (
        .aclk, .aresetn, .cfg_wr_en, .cfg_addr, .cfg_wr_data,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata
    );

    always #6 aclk = ~aclk;

    initial begin
        #15_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // ---------------- predictor ----------------
    function automatic longint sat_t(input longint v);
        return v > SAT_HI ? SAT_HI : (v < SAT_LO ? SAT_LO : v);
    endfunction

    function automatic longint ray_div(input longint num, input longint den);
        longint unsigned a, b, q;
        bit neg;
        if (den == 0) return num < 0 ? SAT_LO : SAT_HI;
        neg = (num < 0) != (den < 0);
        a = num < 0 ? -num : num;
        b = den < 0 ? -den : den;
        if (a >= (64'd1 << 46)) q = 64'd1 << 40;
        else q = (a << 16) / b;
        if (neg) return q > 64'd2147483648 ? SAT_LO : -longint'(q);
        return q > 64'd2147483647 ? SAT_HI : longint'(q);
    endfunction

    function automatic longint mul_floor_q(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p >= 0) return p >>> 16;
        return -((-p + 65535) >>> 16);
    endfunction

    function automatic longint grid_n();
        longint n;
        n = shadow_reg[REG_SUBDIV][6:0];
        if (n < 1) n = 1;
        if (n > 64) n = 64;
        return n;
    endfunction

    function automatic longint cell_of(input int a);
        longint c;
        c = shadow_reg[REG_CELL_X + a][30:0];
        return c < 1 ? 1 : c;
    endfunction

    function automatic longint min_of(input int a);
        return longint'(signed'(shadow_reg[REG_MIN_X + a]));
    endfunction

    function automatic walk_answer_t make_answer(input logic [1:0] v, input longint d);
        walk_answer_t r;
        bit show;
        show = v != VERDICT_MISS;
        r.verdict = v;
        r.index = show ? cur_index : '0;
        for (int a = 0; a < 3; a++) r.vox[a] = show ? cur_vox[a][5:0] : '0;
        r.distance = v == VERDICT_HIT ? d[30:0] : '0;
        return r;
    endfunction

    function automatic void relink_index();
        longint n, v;
        n = grid_n();
        v = cur_vox[0] + cur_vox[1] * n + cur_vox[2] * n * n;
        cur_index = v[17:0];
    endfunction

    function automatic walk_answer_t setup_ray(input ray_item_t it);
        longint mn [3], mx [3], cs [3], o [3], d [3], st [3];
        longint n, best, t, off, idx;
        int cand;
        n = grid_n();
        best = -65536;
        cand = -1;
        is_walking = 0;
        for (int a = 0; a < 3; a++) begin
            mn[a] = min_of(a);
            cs[a] = cell_of(a);
            mx[a] = mn[a] + n * cs[a];
            o[a] = it.org[a];
            d[a] = it.dir[a];
            st[a] = o[a];
        end
        // clip against the box, keep the latest entry
        for (int a = 0; a < 3; a++) begin
            if (o[a] < mn[a]) begin
                if (d[a] < EPS_Q) return make_answer(VERDICT_MISS, 0);
                t = ray_div(mn[a] - o[a], d[a]);
                if (t > best) begin best = t; cand = a; st[a] = mn[a]; end
            end else if (o[a] > mx[a]) begin
                if (d[a] > -EPS_Q) return make_answer(VERDICT_MISS, 0);
                t = ray_div(mx[a] - o[a], d[a]);
                if (t > best) begin best = t; cand = a; st[a] = mx[a]; end
            end
        end
        if (cand >= 0) begin
            if (best < 0) return make_answer(VERDICT_MISS, 0);
            for (int a = 0; a < 3; a++) begin
                if (a == cand) continue;
                st[a] = o[a] + mul_floor_q(best, d[a]);
                if (st[a] < mn[a] || st[a] > mx[a]) return make_answer(VERDICT_MISS, 0);
            end
        end
        // start voxel and boundary parameters
        for (int a = 0; a < 3; a++) begin
            off = st[a] - mn[a];
            idx = off < 0 ? 0 : off / cs[a];
            if (idx > n - 1) idx = n - 1;
            cur_vox[a] = int'(idx);
            if (d[a] > 0) begin
                go_back[a] = 0;
                t_next[a] = ray_div(mn[a] + (idx + 1) * cs[a] - o[a], d[a]);
                t_delta[a] = ray_div(cs[a], d[a]);
            end else begin
                go_back[a] = 1;
                if (d[a] == 0) begin
                    t_next[a] = SAT_HI;
                    t_delta[a] = SAT_HI;
                end else begin
                    t_next[a] = ray_div(mn[a] + idx * cs[a] - o[a], d[a]);
                    t_delta[a] = ray_div(cs[a], -d[a]);
                end
            end
        end
        relink_index();
        is_walking = 1;
        return make_answer(VERDICT_TEST, 0);
    endfunction

    function automatic walk_answer_t advance_walk(input ray_item_t it);
        int a;
        longint hit_len;
        if (!is_walking) return make_answer(VERDICT_MISS, 0);
        if (t_next[0] < t_next[1]) a = t_next[0] < t_next[2] ? 0 : 2;
        else a = t_next[1] < t_next[2] ? 1 : 2;
        hit_len = it.hit_dist;
        if (it.hit_found && hit_len <= t_next[a]) begin
            is_walking = 0;
            return make_answer(VERDICT_HIT, hit_len);
        end
        cur_vox[a] += go_back[a] ? -1 : 1;
        if (cur_vox[a] < 0 || cur_vox[a] >= grid_n()) begin
            is_walking = 0;
            return make_answer(VERDICT_MISS, 0);
        end
        t_next[a] = sat_t(t_next[a] + t_delta[a]);
        relink_index();
        return make_answer(VERDICT_TEST, 0);
    endfunction

    function automatic walk_answer_t predict_answer(input ray_item_t it);
        return it.kind == KIND_RESULT ? advance_walk(it) : setup_ray(it);
    endfunction

    // ---------------- drivers ----------------
    task automatic idle_burst();
        if (!no_idle && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 18)) @(negedge aclk);
    endtask

    // drive one transaction, predict on acceptance
    task automatic send_item(input ray_item_t it, input bit typed, input walk_answer_t typ);
        walk_answer_t w;
        s_tvalid = 1'b0;
        idle_burst();
        s_tdata = {it.hit_dist, it.hit_found, it.dir[2], it.dir[1], it.dir[0],
                   it.org[2], it.org[1], it.org[0]};
        s_tuser = it.kind;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        w = predict_answer(it);
        answer_q = {answer_q, (typed ? typ : w)};
        if (it.kind == KIND_RESULT) results_sent++; else rays_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (answer_q.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (20) @(negedge aclk);
    endtask

    // write one register while idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wr_data = val;
        shadow_reg[idx] = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic load_grid(input logic [31:0] mn, input logic [31:0] cs, input logic [6:0] n);
        drain();
        for (int a = 0; a < 3; a++) write_reg(3'(REG_MIN_X + a), mn);
        for (int a = 0; a < 3; a++) write_reg(3'(REG_CELL_X + a), {1'b0, cs[30:0]});
        write_reg(REG_SUBDIV, {25'd0, n});
    endtask

    // receiver stalls
    initial begin
        @(negedge aclk);
        forever begin
            if (!no_idle && $urandom_range(0, 6) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
                @(negedge aclk);
            end
        end
    end

    // compare every accepted answer with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            walk_answer_t e;
            answers_seen++;
            if (answer_q.size() == 0) begin
                report_mismatch($sformatf("unexpected answer %h", m_tdata));
            end else begin
                e = answer_q.pop_front();
                if (m_tdata[1:0] == VERDICT_HIT) hits_seen++;
                if (m_tdata[1:0] !== e.verdict)
                    report_mismatch($sformatf("verdict %0d exp %0d", m_tdata[1:0], e.verdict));
                if (m_tdata[19:2] !== e.index)
                    report_mismatch($sformatf("index %0d exp %0d", m_tdata[19:2], e.index));
                if (m_tdata[25:20] !== e.vox[0])
                    report_mismatch($sformatf("voxel_x %0d exp %0d", m_tdata[25:20], e.vox[0]));
                if (m_tdata[31:26] !== e.vox[1])
                    report_mismatch($sformatf("voxel_y %0d exp %0d", m_tdata[31:26], e.vox[1]));
                if (m_tdata[37:32] !== e.vox[2])
                    report_mismatch($sformatf("voxel_z %0d exp %0d", m_tdata[37:32], e.vox[2]));
                if (m_tdata[68:38] !== e.distance)
                    report_mismatch($sformatf("distance %h exp %h", m_tdata[68:38],
                                              e.distance));
            end
        end
    end

    // ---------------- stimulus builders ----------------
    function automatic ray_item_t ray_of(input logic [31:0] ox, oy, oz, dx, dy, dz);
        ray_item_t it;
        it.kind = KIND_RAY;
        it.org[0] = ox; it.org[1] = oy; it.org[2] = oz;
        it.dir[0] = dx; it.dir[1] = dy; it.dir[2] = dz;
        it.hit_found = 0;
        it.hit_dist = '0;
        return it;
    endfunction

    function automatic ray_item_t result_of(input bit hf, input logic [30:0] hd);
        ray_item_t it;
        it = ray_of('0, '0, '0, '0, '0, '0);
        it.kind = KIND_RESULT;
        it.hit_found = hf;
        it.hit_dist = hd;
        return it;
    endfunction

    function automatic longint rand64();
        return longint'({$urandom, $urandom} >> 1);
    endfunction

    // random ray aimed mostly at the current box
    function automatic ray_item_t random_ray();
        ray_item_t it;
        longint mn, span, o, tgt, d;
        int mode;
        it = ray_of('0, '0, '0, '0, '0, '0);
        for (int a = 0; a < 3; a++) begin
            mn = min_of(a);
            span = grid_n() * cell_of(a);
            mode = $urandom_range(0, 9);
            if (mode < 6) o = mn + rand64() % (span + 1);
            else if (mode < 9) o = mn - span + rand64() % (3 * span + 1);
            else o = longint'(signed'($urandom));
            o = sat_t(o);
            it.org[a] = o[31:0];
            mode = $urandom_range(0, 9);
            if (mode < 6) begin
                tgt = mn + rand64() % (span + 1);
                d = (tgt - o + longint'($urandom_range(0, 131072)) - 65536)
                    >>> $urandom_range(0, 3);
                d = sat_t(d);
            end else if (mode < 8) begin
                d = longint'($urandom_range(0, 524288)) - 262144;
            end else if (mode == 8) begin
                d = 0;
            end else begin
                d = longint'(signed'($urandom));
            end
            it.dir[a] = d[31:0];
        end
        return it;
    endfunction

    function automatic ray_item_t random_result();
        longint m, hd;
        m = t_next[0];
        if (t_next[1] < m) m = t_next[1];
        if (t_next[2] < m) m = t_next[2];
        if ($urandom_range(0, 1) == 0) begin
            hd = m + $urandom_range(0, 64) - 32;
            if (hd < 0) hd = 0;
            if (hd > SAT_HI) hd = SAT_HI;
        end else begin
            hd = $urandom & 32'h7FFF_FFFF;
        end
        return result_of($urandom_range(0, 3) == 0, hd[30:0]);
    endfunction

    // rays followed by walks, with some noise
    task automatic random_phase(input int count);
        walk_answer_t none;
        int sent, steps;
        none = make_answer(VERDICT_MISS, 0);
        sent = 0;
        while (sent < count) begin
            if (sent > count - 60 && count > 100) no_idle = 1'b1;
            if ($urandom_range(0, 19) == 0) send_item(random_result(), 0, none);
            else send_item(random_ray(), 0, none);
            sent++;
            steps = $urandom_range(4, 40);
            while (is_walking && steps > 0 && sent < count) begin
                if ($urandom_range(0, 39) == 0) send_item(random_ray(), 0, none);
                else send_item(random_result(), 0, none);
                steps--;
                sent++;
            end
        end
    endtask

    // ---------------- main sequence ----------------
    initial begin
        dir_row_t table_rows [$];
        dir_row_t row;
        walk_answer_t miss_answer;
        shadow_reg[REG_MIN_X] = 0; shadow_reg[REG_MIN_Y] = 0; shadow_reg[REG_MIN_Z] = 0;
        shadow_reg[REG_CELL_X] = 65536; shadow_reg[REG_CELL_Y] = 65536;
        shadow_reg[REG_CELL_Z] = 65536; shadow_reg[REG_SUBDIV] = 16;
        for (int a = 0; a < 3; a++) begin
            cur_vox[a] = 0; t_next[a] = 0; t_delta[a] = 0; go_back[a] = 0;
        end
        cur_index = '0;
        is_walking = 0;
        miss_answer.verdict = VERDICT_MISS;
        miss_answer.index = '0;
        for (int a = 0; a < 3; a++) miss_answer.vox[a] = '0;
        miss_answer.distance = '0;

        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // directed table on the reset grid
        row.typed = 1; row.answer = miss_answer;
        row.item = result_of(1, 31'h7FFF_FFFF);                         // result while idle
        table_rows = {table_rows, row};
        row.item = ray_of(-32'sh10000, 32'h8000, 32'h8000, 0, 32'h10000, 0); // behind, no x motion
        table_rows = {table_rows, row};
        row.item = ray_of(32'h8000, 32'h8000, 32'h8000, 32'hFFFF_0000, 0, 0); // inside zero-ish
        row.typed = 0;
        table_rows = {table_rows, row};
        row.item = ray_of(32'h8000, 32'h8000, 32'h8000, 32'h10000, 32'h8000, 32'h4000);
        table_rows = {table_rows, row};
        row.item = result_of(0, 0);                   table_rows = {table_rows, row};
        row.item = result_of(1, 31'h7FFF_FFFF);       table_rows = {table_rows, row};
        row.item = result_of(1, 0);                   table_rows = {table_rows, row};
        row.item = ray_of(-32'sh20000, -32'sh30000, -32'sh40000, 32'h10000, 32'h10000, 32'h10000);
        table_rows = {table_rows, row};
        row.item = result_of(0, 0);                   table_rows = {table_rows, row};
        row.item = result_of(0, 0);                   table_rows = {table_rows, row};
        row.item = ray_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        table_rows = {table_rows, row};
        row.item = ray_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        table_rows = {table_rows, row};
        row.item = result_of(0, 0);                   table_rows = {table_rows, row};
        row.item = ray_of(32'h38000, 32'h58000, 32'h78000, 0, 0, 0);  // all-zero direction
        table_rows = {table_rows, row};
        row.item = result_of(0, 0);                   table_rows = {table_rows, row};
        row.item = result_of(1, 31'd5);               table_rows = {table_rows, row};
        row.item = ray_of(32'h8000, 32'h8000, 32'h8000, 32'h10000, 32'h10000, 32'h10000);
        table_rows = {table_rows, row};               // equal boundaries, tie order
        row.item = result_of(0, 0);                   table_rows = {table_rows, row};
        row.item = ray_of(32'h100000, 32'h100000, 32'h100000,
                          -32'sh10000, -32'sh8000, -32'sh10000); // start on the far bound
        table_rows = {table_rows, row};
        row.item = result_of(0, 0);                   table_rows = {table_rows, row};
        row.item = ray_of(32'h140000, 32'h80000, 32'h80000, -32'sh10000, 0, 0); // enter from above
        table_rows = {table_rows, row};
        row.item = ray_of(32'h80000, 32'h80000, 32'h80000, 32'h10000, 0, 0);    // drop old walk
        table_rows = {table_rows, row};
        row.item = result_of(1, 31'h7FFF_FFFF);       table_rows = {table_rows, row};
        foreach (table_rows[i]) send_item(table_rows[i].item, table_rows[i].typed,
                                          table_rows[i].answer);

        random_phase(40);
        load_grid(-32'sh80000, 32'h10000, 7'd16);
        random_phase(60);
        load_grid(32'h0, 32'h20000, 7'd1);
        random_phase(40);
        load_grid(-32'sh100000, 32'h4000, 7'd64);
        random_phase(70);
        load_grid(32'h0, 32'h0, 7'd0);
        random_phase(20);
        drain();
        write_reg(REG_MIN_X, 32'h18000);
        write_reg(REG_MIN_Y, -32'sh20000);
        write_reg(REG_MIN_Z, 32'h30000);
        write_reg(REG_CELL_X, 32'h38000);
        write_reg(REG_CELL_Y, 32'h10000);
        write_reg(REG_CELL_Z, 32'h8000);
        write_reg(REG_SUBDIV, 32'd127);
        random_phase(60);
        load_grid(32'h8000_0000, 32'h7FFF_FFFF, 7'd1);
        random_phase(30);
        load_grid(32'h7FFF_0000, 32'h10000, 7'd8);
        random_phase(30);
        load_grid(-32'sh40000, 32'h10000, 7'd12);
        random_phase(120);

        drain();
        $display("Covered %0d rays and %0d test results over nine grid settings,",
                 rays_sent, results_sent);
        $display("checked %0d answers (%0d hits), %0d mismatches.",
                 answers_seen, hits_seen, mismatches);
        if (mismatches == 0 && answer_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
